// ----- rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types of the variable-width LZW decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

  // dictionary and stack geometry
  localparam int DictDepth  = 2048;
  localparam int DictAw     = $clog2(DictDepth);
  localparam int StackDepth = 2048;
  localparam int StackAw    = $clog2(StackDepth);
  localparam int CodeW      = 11;
  localparam int NfcW       = 12;
  localparam int LenW       = 12;
  localparam int StepW      = 11;
  localparam int AccW       = 24;
  localparam int HeldW      = 5;
  localparam int WidthW     = 4;

  // output chunking
  localparam int ChunkBytes = 32;
  localparam int ChunkIw    = $clog2(ChunkBytes);
  localparam int CntW       = 6;

  // code values
  localparam logic [CodeW-1:0]  CodeClear = 11'h100;
  localparam logic [CodeW-1:0]  CodeEnd   = 11'h101;
  localparam logic [NfcW-1:0]   CodeFirst = 12'h102;
  localparam logic [CodeW-1:0]  CodeRoot  = 11'h100;
  localparam logic [NfcW-1:0]   WidthBase = 12'h200;
  localparam logic [WidthW-1:0] MinWidth  = 4'd9;
  localparam logic [WidthW-1:0] MaxWidth  = 4'd11;
  localparam logic [StepW-1:0]  StepCap   = 11'd2046;

  // request from the code walker to the chunk emitter
  typedef struct packed {
    logic            start;
    logic            stream_end;
    logic [LenW-1:0] len;
  } emit_req_t;

endpackage

`default_nettype wire

// ----- rtl/lzwd_ram.sv -----
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lzwd_chunker.sv -----
// ----------------------------------------------------------------------------
// lzwd_chunker
// Reads the string stack back to front and packs bytes into output chunks.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_chunker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lzwd_pkg::emit_req_t        req,
  output logic                            busy,
  output logic [lzwd_pkg::StackAw-1:0]    stk_raddr,
  input  wire logic [7:0]                 stk_rdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [63:0]                     out_bytes_word_a,
  output logic [63:0]                     out_bytes_word_b,
  output logic [63:0]                     out_bytes_word_c,
  output logic [63:0]                     out_bytes_word_d,
  output logic [5:0]                      out_byte_count,
  output logic                            out_last_of_code,
  output logic                            out_stream_end
);
  import lzwd_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_EMIT  = 3'b010,
    C_FLUSH = 3'b100
  } cstate_t;

  cstate_t                      state_r, state_nxt;
  logic [LenW-1:0]              len_r, len_nxt;
  logic [LenW-1:0]              iss_r, iss_nxt;
  logic [LenW-1:0]              done_r, done_nxt;
  logic [CntW-1:0]              cnt_r, cnt_nxt;
  logic [CntW-1:0]              icnt_r, icnt_nxt;
  logic                         pend_r, pend_nxt;
  logic                         end_r, end_nxt;
  logic [ChunkBytes-1:0][7:0]   buf_r, buf_nxt;
  logic                         ovalid_r, ovalid_nxt;
  logic [ChunkBytes*8-1:0]      odata_r, odata_nxt;
  logic [CntW-1:0]              ocnt_r, ocnt_nxt;
  logic                         olast_r, olast_nxt;
  logic                         oend_r, oend_nxt;
  logic                         can_issue;
  logic                         slot_free;
  logic [LenW-1:0]              rd_pos;

  assign rd_pos    = len_r - LenW'(1) - iss_r;
  assign stk_raddr = rd_pos[StackAw-1:0];
  assign can_issue = (icnt_r < CntW'(ChunkBytes)) && (iss_r < len_r);
  assign slot_free = !ovalid_r || out_ready;
  assign busy      = (state_r != C_IDLE);

  // emit sequencer
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    iss_nxt    = iss_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    icnt_nxt   = icnt_r;
    pend_nxt   = 1'b0;
    end_nxt    = end_r;
    buf_nxt    = buf_r;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt  = odata_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;
    oend_nxt   = oend_r;
    unique case (state_r)
      C_IDLE: begin
        if (req.start) begin
          len_nxt   = req.len;
          end_nxt   = req.stream_end;
          iss_nxt   = '0;
          done_nxt  = '0;
          cnt_nxt   = '0;
          icnt_nxt  = '0;
          buf_nxt   = '0;
          state_nxt = req.stream_end ? C_FLUSH : C_EMIT;
        end
      end
      C_EMIT: begin
        // capture the word read last cycle
        if (pend_r) begin
          buf_nxt[cnt_r[ChunkIw-1:0]] = stk_rdata;
          cnt_nxt  = cnt_r + CntW'(1);
          done_nxt = done_r + LenW'(1);
        end
        // issue the next stack read
        if (can_issue) begin
          iss_nxt  = iss_r + LenW'(1);
          icnt_nxt = icnt_r + CntW'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = C_FLUSH;
        end
      end
      C_FLUSH: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = buf_r;
          ocnt_nxt   = cnt_r;
          olast_nxt  = !end_r;
          oend_nxt   = end_r;
          buf_nxt    = '0;
          cnt_nxt    = '0;
          icnt_nxt   = '0;
          if (end_r || (done_r == len_r)) begin
            state_nxt = C_IDLE;
          end else begin
            olast_nxt = 1'b0;
            state_nxt = C_EMIT;
          end
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // counters and payload
  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    iss_r   <= iss_nxt;
    done_r  <= done_nxt;
    cnt_r   <= cnt_nxt;
    icnt_r  <= icnt_nxt;
    end_r   <= end_nxt;
    buf_r   <= buf_nxt;
    odata_r <= odata_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_bytes_word_a = odata_r[63:0];
  assign out_bytes_word_b = odata_r[127:64];
  assign out_bytes_word_c = odata_r[191:128];
  assign out_bytes_word_d = odata_r[255:192];
  assign out_byte_count   = ocnt_r;
  assign out_last_of_code = olast_r;
  assign out_stream_end   = oend_r;

endmodule

`default_nettype wire

// ----- rtl/lzw_variable_width_decoder.sv -----
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// LZW decoder for 9 to 11 bit codes, expanded strings out in 32-byte chunks.
// ----------------------------------------------------------------------------
//  channel | ports                                              | dir
//  in      | in_valid, in_ready, in_data_byte, in_first_of_stream | input word
//  out     | out_valid, out_ready, out_bytes_word_a..d,          | result word
//          | out_byte_count, out_last_of_code, out_stream_end    |
//
//  A byte that completes no code only feeds the bit reader. One that completes
//  an ordinary code passes decode, the chain walk (one dictionary read per
//  entry), the entry write and the readback of the stack bytes through the
//  single stack read port, then returns to idle. A clear code returns from
//  decode to idle. Reset is synchronous, active low, memories kept.
//  A stalled output stalls the emitter and input.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_bytes_word_a,
  output logic [63:0]      out_bytes_word_b,
  output logic [63:0]      out_bytes_word_c,
  output logic [63:0]      out_bytes_word_d,
  output logic [5:0]       out_byte_count,
  output logic             out_last_of_code,
  output logic             out_stream_end
);
  import lzwd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_WALK   = 5'b00100,
    S_FINISH = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AccW-1:0]    acc_r, acc_nxt;
  logic [HeldW-1:0]   held_r, held_nxt;
  logic [WidthW-1:0]  width_r, width_nxt;
  logic [NfcW-1:0]    nfc_r, nfc_nxt;
  logic [CodeW-1:0]   prev_r, prev_nxt;
  logic [7:0]         lff_r, lff_nxt;
  logic               aclr_r, aclr_nxt;
  logic               stop_r, stop_nxt;
  logic [CodeW-1:0]   code_r, code_nxt;
  logic [CodeW-1:0]   cur_r, cur_nxt;
  logic [LenW-1:0]    len_r, len_nxt;
  logic [StepW-1:0]   steps_r, steps_nxt;

  // bit reader temporaries
  logic [AccW-1:0]    acc_b, sum, mask;
  logic [HeldW-1:0]   held_b, held_s;
  logic [WidthW-1:0]  width_b;
  logic               stop_b;
  logic [NfcW-1:0]    nfc_inc, thr;
  logic [StepW-1:0]   steps_inc;

  // memory ports
  logic                 dict_we;
  logic [DictAw-1:0]    dict_waddr, dict_raddr;
  logic [CodeW+7:0]     dict_wdata, dict_rdata;
  logic                 stk_we;
  logic [StackAw-1:0]   stk_waddr, stk_raddr;
  logic [7:0]           stk_wdata, stk_rdata;

  emit_req_t            ereq;
  logic                 emit_busy;

  assign in_ready = (state_r == S_IDLE);

  // stream restart view of the stream state
  always_comb begin
    acc_b   = in_first_of_stream ? '0 : acc_r;
    held_b  = in_first_of_stream ? '0 : held_r;
    width_b = in_first_of_stream ? MinWidth : width_r;
    stop_b  = in_first_of_stream ? 1'b0 : stop_r;
    sum     = acc_b | (AccW'(in_data_byte) << held_b);
    held_s  = held_b + HeldW'(8);
    mask    = (AccW'(1) << width_b) - AccW'(1);
  end

  assign nfc_inc   = (nfc_r < NfcW'(DictDepth)) ? nfc_r + NfcW'(1) : nfc_r;
  assign thr       = WidthBase << (width_r - MinWidth);
  assign steps_inc = steps_r + StepW'(1);

  // code sequencer
  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    width_nxt  = width_r;
    nfc_nxt    = nfc_r;
    prev_nxt   = prev_r;
    lff_nxt    = lff_r;
    aclr_nxt   = aclr_r;
    stop_nxt   = stop_r;
    code_nxt   = code_r;
    cur_nxt    = cur_r;
    len_nxt    = len_r;
    steps_nxt  = steps_r;
    dict_we    = 1'b0;
    dict_waddr = nfc_r[DictAw-1:0];
    dict_wdata = {prev_r, cur_r[7:0]};
    dict_raddr = cur_r[DictAw-1:0];
    stk_we     = 1'b0;
    stk_waddr  = len_r[StackAw-1:0];
    stk_wdata  = cur_r[7:0];
    ereq       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = acc_b;
          held_nxt  = held_b;
          width_nxt = width_b;
          stop_nxt  = stop_b;
          if (in_first_of_stream) begin
            nfc_nxt  = CodeFirst;
            prev_nxt = '0;
            lff_nxt  = '0;
            aclr_nxt = 1'b0;
          end
          if (!stop_b) begin
            if (held_s >= HeldW'(width_b)) begin
              code_nxt  = sum[CodeW-1:0] & mask[CodeW-1:0];
              acc_nxt   = sum >> width_b;
              held_nxt  = held_s - HeldW'(width_b);
              state_nxt = S_DECODE;
            end else begin
              acc_nxt  = sum;
              held_nxt = held_s;
            end
          end
        end
      end
      S_DECODE: begin
        if (aclr_r) begin
          // literal right after a clear
          aclr_nxt   = 1'b0;
          prev_nxt   = code_r;
          lff_nxt    = code_r[7:0];
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = code_r[7:0];
          ereq.start = 1'b1;
          ereq.len   = LenW'(1);
          state_nxt  = S_WAIT;
        end else if (code_r == CodeEnd) begin
          stop_nxt        = 1'b1;
          ereq.start      = 1'b1;
          ereq.stream_end = 1'b1;
          state_nxt       = S_WAIT;
        end else if (code_r == CodeClear) begin
          width_nxt = MinWidth;
          nfc_nxt   = CodeFirst;
          aclr_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          steps_nxt = '0;
          if (NfcW'(code_r) >= nfc_r) begin
            // code not yet defined: previous string plus its first byte
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = lff_r;
            len_nxt   = LenW'(1);
            cur_nxt   = prev_r;
          end else begin
            len_nxt = '0;
            cur_nxt = code_r;
          end
          dict_raddr = cur_nxt[DictAw-1:0];
          state_nxt  = (cur_nxt >= CodeRoot) ? S_WALK : S_FINISH;
        end
      end
      S_WALK: begin
        // one chain entry per cycle
        stk_we    = 1'b1;
        stk_wdata = dict_rdata[7:0];
        len_nxt   = len_r + LenW'(1);
        steps_nxt = steps_inc;
        cur_nxt   = dict_rdata[CodeW+7:8];
        dict_raddr = cur_nxt[DictAw-1:0];
        if (!((cur_nxt >= CodeRoot) && (steps_inc < StepCap))) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        stk_we     = 1'b1;
        len_nxt    = len_r + LenW'(1);
        lff_nxt    = cur_r[7:0];
        dict_we    = (nfc_r < NfcW'(DictDepth));
        nfc_nxt    = nfc_inc;
        prev_nxt   = code_r;
        if ((width_r < MaxWidth) && (nfc_inc >= thr)) begin
          width_nxt = width_r + WidthW'(1);
        end
        ereq.start = 1'b1;
        ereq.len   = len_nxt;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (!emit_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
      held_r  <= '0;
      width_r <= MinWidth;
      nfc_r   <= CodeFirst;
      prev_r  <= '0;
      lff_r   <= '0;
      aclr_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      width_r <= width_nxt;
      nfc_r   <= nfc_nxt;
      prev_r  <= prev_nxt;
      lff_r   <= lff_nxt;
      aclr_r  <= aclr_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // per-code working registers
  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    cur_r   <= cur_nxt;
    len_r   <= len_nxt;
    steps_r <= steps_nxt;
  end

  // dictionary: prefix in high bits, suffix in low byte
  lzwd_ram #(.Width(CodeW + 8), .Depth(DictDepth)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  // string stack for one expansion
  lzwd_ram #(.Width(8), .Depth(StackDepth)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  lzwd_chunker u_chunker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (ereq),
    .busy             (emit_busy),
    .stk_raddr        (stk_raddr),
    .stk_rdata        (stk_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bytes_word_a (out_bytes_word_a),
    .out_bytes_word_b (out_bytes_word_b),
    .out_bytes_word_c (out_bytes_word_c),
    .out_bytes_word_d (out_bytes_word_d),
    .out_byte_count   (out_byte_count),
    .out_last_of_code (out_last_of_code),
    .out_stream_end   (out_stream_end)
  );

`ifndef SYNTHESIS
  // no new word while the stack is still being read back
  a_idle_not_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !emit_busy) else $error("input taken while emitter busy");

  // code width stays within 9..11
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r >= MinWidth) && (width_r <= MaxWidth)) else $error("code width out of range");

  // dictionary never grows past its depth
  a_nfc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r <= NfcW'(DictDepth)) else $error("dictionary overflow");

  // an emit request is only made when the emitter is free
  a_req_free: assert property (@(posedge clk) disable iff (!rst_n)
    ereq.start |-> !emit_busy) else $error("emit request while busy");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_lzw_variable_width_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_lzw_variable_width_decoder
// Self-checking bench for the variable-width LZW decoder. Compressed streams,
// some with out-of-range codes, are built code by code, packed LSB first and
// driven as bytes. A bit-accurate expander predicts every output chunk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_lzw_variable_width_decoder;
  import lzwd_pkg::*;

  localparam int WatchLimit = 40000;

  typedef struct {
    logic [63:0] wa, wb, wc, wd;
    logic [5:0]  cnt;
    logic        last;
    logic        send;
  } chunk_t;

  // expander model plus store of expected chunks
  class lzw_expander;
    logic [CodeW-1:0] pfx[DictDepth];
    logic [7:0]       sfx[DictDepth];
    logic [7:0]       stk[StackDepth];
    logic [31:0]      acc;
    int               held, cw, nfc;
    logic [CodeW-1:0] prev;
    logic [7:0]       lfc;
    bit               clr_seen, stopped;
    chunk_t           chunk_q[$];
    int               errors, chunks_seen;

    function new();
      foreach (pfx[i]) begin
        pfx[i] = '0;
        sfx[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      acc = 0; held = 0; cw = 9; nfc = CodeFirst;
      prev = '0; lfc = '0; clr_seen = 0; stopped = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // split stack (reversed) into chunks
    function void push_chunks(int len);
      chunk_t ch;
      logic [255:0] bits;
      int done, n;
      done = 0;
      while (done < len && chunk_q.size() >= 0) begin
        n = (len - done > ChunkBytes) ? ChunkBytes : len - done;
        bits = '0;
        for (int i = 0; i < n; i++) bits[8*i +: 8] = stk[len - 1 - (done + i)];
        done += n;
        ch.wa = bits[63:0]; ch.wb = bits[127:64];
        ch.wc = bits[191:128]; ch.wd = bits[255:192];
        ch.cnt = n[5:0]; ch.last = (done >= len); ch.send = 0;
        chunk_q.push_back(ch);
      end
    endfunction

    function void expand(int c);
      chunk_t ch;
      int len, cur, steps;
      logic [7:0] first;
      len = 0; steps = 0;
      if (clr_seen) begin
        clr_seen = 0;
        prev = c[CodeW-1:0];
        lfc = c[7:0];
        stk[0] = lfc;
        push_chunks(1);
        return;
      end
      if (c == CodeEnd) begin
        stopped = 1;
        ch = '{default: '0};
        ch.send = 1;
        chunk_q.push_back(ch);
        return;
      end
      if (c == CodeClear) begin
        cw = 9; nfc = CodeFirst; clr_seen = 1;
        return;
      end
      cur = c;
      if (c >= nfc) begin
        cur = prev;
        stk[len++] = lfc;
      end
      while (cur >= 'h100 && steps < StepCap) begin
        stk[len++] = (cur < DictDepth) ? sfx[cur] : 8'h00;
        cur = (cur < DictDepth) ? pfx[cur] : 0;
        steps++;
      end
      first = cur[7:0];
      stk[len++] = first;
      lfc = first;
      if (nfc < DictDepth) begin
        sfx[nfc] = first;
        pfx[nfc] = prev;
        nfc++;
      end
      prev = c[CodeW-1:0];
      if (cw < MaxWidth && nfc >= ('h200 << (cw - 9))) cw++;
      push_chunks(len);
    endfunction

    function void take_byte(logic [7:0] b, logic fos);
      int c;
      if (fos) restart();
      if (stopped) return;
      acc |= 32'(b) << held;
      held += 8;
      while (held >= cw && !stopped) begin
        c = acc & ((1 << cw) - 1);
        acc >>= cw;
        held -= cw;
        expand(c);
      end
      acc &= 32'hFF_FFFF;
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t exp_c;
      chunks_seen++;
      if (chunk_q.size() == 0) begin
        report($sformatf("unexpected word, count %0d end %0b", got.cnt, got.send));
        return;
      end
      exp_c = chunk_q.pop_front();
      if (got.wa !== exp_c.wa) report($sformatf("word_a %h exp %h", got.wa, exp_c.wa));
      if (got.wb !== exp_c.wb) report($sformatf("word_b %h exp %h", got.wb, exp_c.wb));
      if (got.wc !== exp_c.wc) report($sformatf("word_c %h exp %h", got.wc, exp_c.wc));
      if (got.wd !== exp_c.wd) report($sformatf("word_d %h exp %h", got.wd, exp_c.wd));
      if (got.cnt !== exp_c.cnt)
        report($sformatf("byte_count %0d exp %0d", got.cnt, exp_c.cnt));
      if (got.last !== exp_c.last)
        report($sformatf("last_of_code %b exp %b", got.last, exp_c.last));
      if (got.send !== exp_c.send)
        report($sformatf("stream_end %b exp %b", got.send, exp_c.send));
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_first_of_stream;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [63:0] out_bytes_word_a, out_bytes_word_b, out_bytes_word_c, out_bytes_word_d;
  logic [5:0]  out_byte_count;
  logic        out_last_of_code, out_stream_end;

  lzw_variable_width_decoder dut (.*);

  lzw_expander model = new();

  // stream builder state (mirrors the decoder at code level)
  logic [7:0] byte_q[$];
  logic       fos_q[$];
  int  pk_acc, pk_held, pk_w, pk_nfc;
  bit  pk_clr, pk_break, pk_fos, long_mode;
  bit  idle_on = 1;
  int  words_sent, streams_built, codes_built, wd_count;

  initial begin
    clk = 0;
    forever begin
      #10 clk = 1;
      #10 clk = 0;
    end
  end

  // accepted words go to the model / get checked
  always @(posedge clk) begin
    chunk_t got;
    if (rst_n && in_valid && in_ready) model.take_byte(in_data_byte, in_first_of_stream);
    if (rst_n && out_valid && out_ready) begin
      got.wa = out_bytes_word_a; got.wb = out_bytes_word_b;
      got.wc = out_bytes_word_c; got.wd = out_bytes_word_d;
      got.cnt = out_byte_count; got.last = out_last_of_code; got.send = out_stream_end;
      model.check_chunk(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) wd_count <= 0;
    else if (wd_count >= WatchLimit) begin
      $display("timeout: no handshake for %0d cycles", WatchLimit);
      $display("** lzw_variable_width_decoder: FAILED **");
      $finish;
    end else wd_count <= wd_count + 1;
  end

  // result side backpressure in bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic start_stream();
    pk_acc = 0; pk_held = 0; pk_w = 9; pk_nfc = CodeFirst;
    pk_clr = 0; pk_break = 0; pk_fos = 1;
    streams_built++;
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_q.push_back(b);
    fos_q.push_back(pk_fos);
    pk_fos = 0;
  endtask

  // pack one code at the current width, then advance the mirror
  task automatic put_code(int c);
    pk_acc |= c << pk_held;
    pk_held += pk_w;
    while (pk_held >= 8) begin
      push_byte(pk_acc[7:0]);
      pk_acc >>= 8;
      pk_held -= 8;
    end
    codes_built++;
    if (pk_clr) pk_clr = 0;
    else if (c == CodeClear) begin
      pk_w = 9; pk_nfc = CodeFirst; pk_clr = 1;
    end else if (c != CodeEnd) begin
      if (pk_nfc < DictDepth) pk_nfc++;
      if (pk_w < MaxWidth && pk_nfc >= ('h200 << (pk_w - 9))) pk_w++;
    end
  endtask

  task automatic flush_bits();
    int pad;
    pad = $urandom;
    if (pk_held > 0) push_byte(8'(pk_acc | (pad << pk_held)));
    pk_acc = 0; pk_held = 0;
  endtask

  // choose a code that keeps every dictionary walk on written entries
  function automatic int pick_code();
    int r, top;
    r = $urandom_range(0, 99);
    top = (1 << pk_w) - 1;
    if (pk_break) begin
      pk_break = 0;
      return r < 50 ? int'(CodeClear) : int'(CodeEnd);
    end
    if (pk_clr) begin
      if (r < 8) begin
        pk_break = 1;
        return $urandom_range('h100, 'h1FF);
      end
      return $urandom_range(0, 255);
    end
    if (long_mode) begin
      if (r < 85 || pk_nfc <= CodeFirst) return $urandom_range(0, 255);
      return $urandom_range(CodeFirst, pk_nfc - 1);
    end
    if (r < 5) return CodeClear;
    if (r < 45 || pk_nfc <= CodeFirst) return $urandom_range(0, 255);
    if (r < 60) return $urandom_range(CodeFirst, pk_nfc - 1);
    if (r < 80) return pk_nfc - 1 - $urandom_range(0, (pk_nfc - 'h103 < 8) ? pk_nfc - 'h103 : 8);
    if (r < 96 && pk_nfc < DictDepth) return pk_nfc;
    if (pk_nfc + 1 <= top) begin
      pk_break = 1;
      return $urandom_range(pk_nfc + 1, top);
    end
    return $urandom_range(0, 255);
  endfunction

  // ignored bytes after an end code
  task automatic add_junk(int n);
    for (int i = 0; i < n; i++) begin
      byte_q.push_back(8'($urandom));
      fos_q.push_back(1'b0);
    end
  endtask

  task automatic random_stream(int ncodes);
    start_stream();
    for (int i = 0; i < ncodes; i++) put_code(pick_code());
    if ($urandom_range(0, 9) < 7) begin
      put_code(CodeEnd);
      flush_bits();
      add_junk($urandom_range(0, 3));
    end
  endtask

  // drive queued bytes, one word per handshake
  task automatic send_all(bit counted);
    logic [7:0] b;
    logic f;
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      f = fos_q.pop_front();
      if (idle_on && $urandom_range(0, 4) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      in_valid <= 1;
      in_data_byte <= b;
      in_first_of_stream <= f;
      forever begin
        @(posedge clk);
        if (in_ready) break;
      end
      if (counted) words_sent++;
      @(negedge clk);
    end
    in_valid <= 0;
  endtask

  task automatic drain();
    while (model.chunk_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_data_byte = '0; in_first_of_stream = 0;
    out_ready = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: literals, defined and not-yet-defined codes, clears,
    // odd literals after clear, end code and trailing ignored bytes
    start_stream();
    put_code('h41); put_code('h42); put_code('h102); put_code('h104);
    put_code(CodeClear); put_code('hFF);
    put_code(CodeClear); put_code(CodeEnd);
    put_code(CodeClear); put_code('h00); put_code('h1FF);
    put_code(CodeEnd);
    flush_bits();
    add_junk(1);
    byte_q.push_back(8'h00); fos_q.push_back(1'b0);
    byte_q.push_back(8'hFF); fos_q.push_back(1'b0);
    send_all(1);
    drain();

    // random streams, mostly short
    while (words_sent < 40) begin
      random_stream($urandom_range(4, 60));
      send_all(1);
    end
    drain();

    // one stream long enough to step the code width up to 10 bits
    long_mode = 1;
    start_stream();
    while (pk_nfc < int'(WidthBase) + 8) put_code(pick_code());
    put_code(CodeEnd);
    flush_bits();
    long_mode = 0;
    send_all(1);

    // final stretch with no idling on either side
    idle_on = 0;
    do begin
      random_stream($urandom_range(4, 60));
      send_all(1);
    end while (words_sent < 440);
    drain();

    $display("covered %0d streams, %0d codes, %0d input words, %0d output words",
             streams_built, codes_built, words_sent, model.chunks_seen);
    $display("code width stepped to 10 bits once; %0d mismatches", model.errors);
    if (model.errors == 0 && model.chunk_q.size() == 0)
      $display("** lzw_variable_width_decoder: PASSED **");
    else
      $display("** lzw_variable_width_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
